[rtl/core/lpft_pkg.sv]
`timescale 1ns / 1ps
// shared types and constants of the lidar point filter and transform unit
// no dependencies; used by lpft_row, lidar_point_filter_transform_unit and tb

package lpft_pkg;

	localparam int CoordW   = 16;              // point coordinate, 1/512 m
	localparam int CoefW    = 16;              // rotation coefficient, Q2.14
	localparam int ProdW    = 2 * CoefW;       // one coefficient product
	localparam int RowSumW  = ProdW + 2;       // three products plus translation
	localparam int RangeW   = 2 * CoordW;      // x*x + y*y
	localparam int LimitW   = 31;              // range limit registers
	localparam int ScaleW   = 16;              // cells per metre, Q8.8
	localparam int MapProdW = RowSumW + ScaleW + 1;
	localparam int RoundW   = MapProdW + 5;
	localparam int MapW     = 32;
	localparam int FracBits = 14;
	localparam int MapShift = 23;
	localparam int CfgDataW = 64;
	localparam int CfgAddrW = 6;

	localparam logic [RangeW-1:0] BehindLimit = RangeW'(131072);

	// configuration register indexes, 8 bytes apart
	typedef enum logic [2:0] {
		REG_ROT_ROW_X  = 3'd0,
		REG_ROT_ROW_Y  = 3'd1,
		REG_ROT_ROW_Z  = 3'd2,
		REG_MIN_RANGE  = 3'd3,
		REG_MAX_RANGE  = 3'd4,
		REG_HEIGHT_MIN = 3'd5,
		REG_HEIGHT_MAX = 3'd6,
		REG_CELLS_PM   = 3'd7
	} lpft_reg_t;

	localparam logic [CfgDataW-1:0] RotRowXReset = 64'h0000_0000_0000_4000;
	localparam logic [CfgDataW-1:0] RotRowYReset = 64'h0000_0000_4000_0000;
	localparam logic [CfgDataW-1:0] RotRowZReset = 64'h0000_4000_0000_0000;
	localparam logic [LimitW-1:0]   MinRangeReset = 31'd41943;
	localparam logic [LimitW-1:0]   MaxRangeReset = 31'd235929600;
	localparam logic [CoordW-1:0]   HeightMinReset = 16'hFE00;
	localparam logic [CoordW-1:0]   HeightMaxReset = 16'h0200;
	localparam logic [ScaleW-1:0]   CellsPmReset = 16'd10240;

	// load enables of the first two pipeline stages
	typedef struct packed {
		logic s1;
		logic s2;
	} lpft_stage_en_t;

endpackage

[rtl/core/lpft_row.sv]
`timescale 1ns / 1ps
// one row of the rigid transform: three coefficient products, then their sum plus translation
// depends on lpft_pkg

module lpft_row (
	input  logic                                  clk,
	input  lpft_pkg::lpft_stage_en_t              en,
	input  logic signed [lpft_pkg::CoordW-1:0]    x,
	input  logic signed [lpft_pkg::CoordW-1:0]    y,
	input  logic signed [lpft_pkg::CoordW-1:0]    z,
	input  logic [lpft_pkg::CfgDataW-1:0]         row,
	output logic signed [lpft_pkg::RowSumW-1:0]   sum_s2
);

	logic signed [lpft_pkg::ProdW-1:0]   px_s1;
	logic signed [lpft_pkg::ProdW-1:0]   py_s1;
	logic signed [lpft_pkg::ProdW-1:0]   pz_s1;
	logic signed [lpft_pkg::CoefW-1:0]   trans_s1;
	logic signed [lpft_pkg::RowSumW-1:0] sum_d;

	always_ff @(posedge clk) begin
		if (en.s1) begin
			px_s1    <= $signed(row[15:0]) * x;
			py_s1    <= $signed(row[31:16]) * y;
			pz_s1    <= $signed(row[47:32]) * z;
			trans_s1 <= $signed(row[63:48]);
		end
	end

	// translation is at 1/512 m, products at 2^-14 of that
	always_comb begin
		sum_d = lpft_pkg::RowSumW'(px_s1) + lpft_pkg::RowSumW'(py_s1)
			+ lpft_pkg::RowSumW'(pz_s1)
			+ $signed({{(lpft_pkg::RowSumW - lpft_pkg::CoefW - lpft_pkg::FracBits)
				{trans_s1[lpft_pkg::CoefW-1]}}, trans_s1, {lpft_pkg::FracBits{1'b0}}});
	end

	always_ff @(posedge clk) begin
		if (en.s2) begin
			sum_s2 <= sum_d;
		end
	end

endmodule

[rtl/core/lidar_point_filter_transform_unit.sv]
`timescale 1ns / 1ps
// Lidar point filter and transform unit: takes one point per cycle, unless stalled, in the
// laser frame (1/512 m), tests planar range, the near-behind zone and relative height, then
// rotates, translates and scales kept points into map units of 1/256 cell. Every item yields
// one result item, which passes the four pipeline stages (products, sums, tests and scale
// multiply, rounding into the output register); a new item can enter every cycle while the
// output is not stalled. Backpressure stalls each full stage from the output register back;
// empty stages still load. Dropped points come out with keep low and zero coordinates;
// tlast follows its point. Registers sit on an APB port at 8-byte steps; they are to be
// written only while the pipeline is empty, and the block itself does not enforce this.
// depends on lpft_pkg and lpft_row.

module lidar_point_filter_transform_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	// input items
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [47:0]                     s_axis_tdata,  // pt_x[15:0], pt_y[31:16], pt_z[47:32]
	input  logic                            s_axis_tlast,  // last_in
	// result items
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [63:0]                     m_axis_tdata,  // map_x[31:0], map_y[63:32]
	output logic                            m_axis_tuser,  // keep
	output logic                            m_axis_tlast,  // last_out
	// register port
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [lpft_pkg::CfgAddrW-1:0]   paddr,
	input  logic [lpft_pkg::CfgDataW-1:0]   pwdata,
	output logic [lpft_pkg::CfgDataW-1:0]   prdata,
	output logic                            pready
);

	// ------------------------------------------------------------------
	// configuration registers
	// ------------------------------------------------------------------
	logic [lpft_pkg::CfgDataW-1:0] rot_row_x_q;
	logic [lpft_pkg::CfgDataW-1:0] rot_row_y_q;
	logic [lpft_pkg::CfgDataW-1:0] rot_row_z_q;
	logic [lpft_pkg::LimitW-1:0]   min_range_sq_q;
	logic [lpft_pkg::LimitW-1:0]   max_range_sq_q;
	logic [lpft_pkg::CoordW-1:0]   height_min_q;
	logic [lpft_pkg::CoordW-1:0]   height_max_q;
	logic [lpft_pkg::ScaleW-1:0]   cells_per_metre_q;

	lpft_pkg::lpft_reg_t reg_idx;
	logic                cfg_wr;

	assign pready  = 1'b1;
	assign reg_idx = lpft_pkg::lpft_reg_t'(paddr[lpft_pkg::CfgAddrW-1:3]);
	assign cfg_wr  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_row_x_q       <= lpft_pkg::RotRowXReset;
			rot_row_y_q       <= lpft_pkg::RotRowYReset;
			rot_row_z_q       <= lpft_pkg::RotRowZReset;
			min_range_sq_q    <= lpft_pkg::MinRangeReset;
			max_range_sq_q    <= lpft_pkg::MaxRangeReset;
			height_min_q      <= lpft_pkg::HeightMinReset;
			height_max_q      <= lpft_pkg::HeightMaxReset;
			cells_per_metre_q <= lpft_pkg::CellsPmReset;
		end else if (cfg_wr) begin
			case (reg_idx)
				lpft_pkg::REG_ROT_ROW_X:  rot_row_x_q <= pwdata;
				lpft_pkg::REG_ROT_ROW_Y:  rot_row_y_q <= pwdata;
				lpft_pkg::REG_ROT_ROW_Z:  rot_row_z_q <= pwdata;
				lpft_pkg::REG_MIN_RANGE:  min_range_sq_q <= pwdata[lpft_pkg::LimitW-1:0];
				lpft_pkg::REG_MAX_RANGE:  max_range_sq_q <= pwdata[lpft_pkg::LimitW-1:0];
				lpft_pkg::REG_HEIGHT_MIN: height_min_q <= pwdata[lpft_pkg::CoordW-1:0];
				lpft_pkg::REG_HEIGHT_MAX: height_max_q <= pwdata[lpft_pkg::CoordW-1:0];
				lpft_pkg::REG_CELLS_PM:   cells_per_metre_q <= pwdata[lpft_pkg::ScaleW-1:0];
				default: ;
			endcase
		end
	end

	// read back, narrow registers zero extended
	always_comb begin
		case (reg_idx)
			lpft_pkg::REG_ROT_ROW_X:  prdata = rot_row_x_q;
			lpft_pkg::REG_ROT_ROW_Y:  prdata = rot_row_y_q;
			lpft_pkg::REG_ROT_ROW_Z:  prdata = rot_row_z_q;
			lpft_pkg::REG_MIN_RANGE:  prdata = lpft_pkg::CfgDataW'(min_range_sq_q);
			lpft_pkg::REG_MAX_RANGE:  prdata = lpft_pkg::CfgDataW'(max_range_sq_q);
			lpft_pkg::REG_HEIGHT_MIN: prdata = lpft_pkg::CfgDataW'(height_min_q);
			lpft_pkg::REG_HEIGHT_MAX: prdata = lpft_pkg::CfgDataW'(height_max_q);
			lpft_pkg::REG_CELLS_PM:   prdata = lpft_pkg::CfgDataW'(cells_per_metre_q);
			default:                  prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// pipeline control: a stage loads when it is empty or the next one moves
	// ------------------------------------------------------------------
	logic v_s1, v_s2, v_s3, v_s4;
	logic en1, en2, en3, en4;
	lpft_pkg::lpft_stage_en_t row_en;

	assign en4 = ~v_s4 | m_axis_tready;
	assign en3 = ~v_s3 | en4;
	assign en2 = ~v_s2 | en3;
	assign en1 = ~v_s1 | en2;
	assign s_axis_tready = en1;
	assign row_en = '{s1: en1, s2: en2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en1) v_s1 <= s_axis_tvalid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
		end
	end

	// ------------------------------------------------------------------
	// stage 1: squares for planar range, sign of x, framing
	// ------------------------------------------------------------------
	logic signed [lpft_pkg::CoordW-1:0] pt_x, pt_y, pt_z;
	logic signed [lpft_pkg::ProdW-1:0]  xx_s1, yy_s1;
	logic                               xneg_s1, last_s1;

	assign pt_x = $signed(s_axis_tdata[15:0]);
	assign pt_y = $signed(s_axis_tdata[31:16]);
	assign pt_z = $signed(s_axis_tdata[47:32]);

	always_ff @(posedge clk) begin
		if (en1) begin
			xx_s1   <= pt_x * pt_x;
			yy_s1   <= pt_y * pt_y;
			xneg_s1 <= pt_x[lpft_pkg::CoordW-1];
			last_s1 <= s_axis_tlast;
		end
	end

	// transform rows; the z row carries no translation for relative height
	logic signed [lpft_pkg::RowSumW-1:0] px_s2, py_s2, h_s2;
	logic [lpft_pkg::CfgDataW-1:0]       row_z_rot;

	assign row_z_rot = {16'd0, rot_row_z_q[47:0]};

	lpft_row u_row_x (
		.clk(clk), .en(row_en), .x(pt_x), .y(pt_y), .z(pt_z),
		.row(rot_row_x_q), .sum_s2(px_s2)
	);

	lpft_row u_row_y (
		.clk(clk), .en(row_en), .x(pt_x), .y(pt_y), .z(pt_z),
		.row(rot_row_y_q), .sum_s2(py_s2)
	);

	lpft_row u_row_z (
		.clk(clk), .en(row_en), .x(pt_x), .y(pt_y), .z(pt_z),
		.row(row_z_rot), .sum_s2(h_s2)
	);

	// ------------------------------------------------------------------
	// stage 2: planar range squared (both squares are non-negative)
	// ------------------------------------------------------------------
	logic [lpft_pkg::RangeW-1:0] d_s2;
	logic                        xneg_s2, last_s2;

	always_ff @(posedge clk) begin
		if (en2) begin
			d_s2    <= lpft_pkg::RangeW'($unsigned(xx_s1)) + lpft_pkg::RangeW'($unsigned(yy_s1));
			xneg_s2 <= xneg_s1;
			last_s2 <= last_s1;
		end
	end

	// ------------------------------------------------------------------
	// stage 3: all pass/drop tests, scale multiply
	// ------------------------------------------------------------------
	logic signed [lpft_pkg::RowSumW-1:0]  h_lo, h_hi;
	logic                                 range_ok, behind, height_ok;
	logic signed [lpft_pkg::ScaleW:0]     scale;
	logic signed [lpft_pkg::MapProdW-1:0] mx_prod_s3, my_prod_s3;
	logic                                 keep_s3, last_s3;

	// height limits moved to the 2^-14 scale of the row sums
	assign h_lo = $signed({{(lpft_pkg::RowSumW - lpft_pkg::CoordW - lpft_pkg::FracBits)
		{height_min_q[lpft_pkg::CoordW-1]}}, height_min_q, {lpft_pkg::FracBits{1'b0}}});
	assign h_hi = $signed({{(lpft_pkg::RowSumW - lpft_pkg::CoordW - lpft_pkg::FracBits)
		{height_max_q[lpft_pkg::CoordW-1]}}, height_max_q, {lpft_pkg::FracBits{1'b0}}});

	assign range_ok  = (d_s2 > lpft_pkg::RangeW'(min_range_sq_q))
		&& (d_s2 < lpft_pkg::RangeW'(max_range_sq_q));
	// within half a square metre behind the sensor
	assign behind    = xneg_s2 && (d_s2 < lpft_pkg::BehindLimit);
	assign height_ok = (h_s2 > h_lo) && (h_s2 < h_hi);
	assign scale     = $signed({1'b0, cells_per_metre_q});

	always_ff @(posedge clk) begin
		if (en3) begin
			mx_prod_s3 <= px_s2 * scale;
			my_prod_s3 <= py_s2 * scale;
			keep_s3    <= range_ok && !behind && height_ok;
			last_s3    <= last_s2;
		end
	end

	// ------------------------------------------------------------------
	// stage 4: round half up into 1/256 cell, output register
	// ------------------------------------------------------------------
	localparam logic signed [lpft_pkg::RoundW-1:0] RoundHalf =
		lpft_pkg::RoundW'(1) <<< (lpft_pkg::MapShift - 1);

	logic signed [lpft_pkg::RoundW-1:0] mx_round, my_round;
	logic [lpft_pkg::MapW-1:0]          map_x_s4, map_y_s4;
	logic                               keep_s4, last_s4;

	assign mx_round = lpft_pkg::RoundW'(mx_prod_s3) + RoundHalf;
	assign my_round = lpft_pkg::RoundW'(my_prod_s3) + RoundHalf;

	always_ff @(posedge clk) begin
		if (en4) begin
			map_x_s4 <= keep_s3
				? mx_round[lpft_pkg::MapShift + lpft_pkg::MapW - 1:lpft_pkg::MapShift] : '0;
			map_y_s4 <= keep_s3
				? my_round[lpft_pkg::MapShift + lpft_pkg::MapW - 1:lpft_pkg::MapShift] : '0;
			keep_s4  <= keep_s3;
			last_s4  <= last_s3;
		end
	end

	assign m_axis_tvalid = v_s4;
	assign m_axis_tdata  = {map_y_s4, map_x_s4};
	assign m_axis_tuser  = keep_s4;
	assign m_axis_tlast  = last_s4;

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps
// self-checking bench for lidar_point_filter_transform_unit: range, behind-zone and height
// filtering plus the rigid transform into map units; depends on lpft_pkg and the unit itself

module tb;

	// one result item as the unit should produce it
	typedef struct packed {
		logic [31:0] map_x;
		logic [31:0] map_y;
		logic        keep;
		logic        last;
	} map_item_t;

	localparam time RunLimit = 5ms;

	logic                          clk;
	logic                          arst_n;
	logic                          s_axis_tvalid;
	logic                          s_axis_tready;
	logic [47:0]                   s_axis_tdata;   // pt_x[15:0], pt_y[31:16], pt_z[47:32]
	logic                          s_axis_tlast;   // last_in
	logic                          m_axis_tvalid;
	logic                          m_axis_tready = 1'b0;
	logic [63:0]                   m_axis_tdata;   // map_x[31:0], map_y[63:32]
	logic                          m_axis_tuser;   // keep
	logic                          m_axis_tlast;   // last_out
	logic                          psel;
	logic                          penable;
	logic                          pwrite;
	logic [lpft_pkg::CfgAddrW-1:0] paddr;
	logic [lpft_pkg::CfgDataW-1:0] pwdata;
	logic [lpft_pkg::CfgDataW-1:0] prdata;
	logic                          pready;

	// shadow of the register file, kept masked to each register's width
	logic [63:0] cfg_regs [8];
	// results predicted for accepted points, oldest first
	map_item_t   pending_maps [$];
	int unsigned errors = 0;
	// no idling on either side while set
	bit          quiet = 1'b0;

	lidar_point_filter_transform_unit uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hard stop in case a handshake never completes
	initial begin
		#(RunLimit);
		$display("FAILURE");
		$finish;
	end

	// ---------------------------------------------------------------- predictor

	// signed 16-bit slot of a packed row; slot 3 is the translation
	function automatic longint row_coef(logic [63:0] row, int slot);
		logic signed [15:0] c;
		c = row[16*slot +: 16];
		return c;
	endfunction

	// rotation part of one row, exact, in 2^-14 / 512 m
	function automatic longint row_dot(logic [63:0] row, longint x, longint y, longint z);
		return row_coef(row, 0) * x + row_coef(row, 1) * y + row_coef(row, 2) * z;
	endfunction

	// scale by cells per metre and round half up into 1/256 cell
	function automatic logic [31:0] scale_to_map(longint p);
		longint s;
		s = p * longint'(cfg_regs[lpft_pkg::REG_CELLS_PM])
			+ (longint'(1) <<< (lpft_pkg::MapShift - 1));
		s = s >>> lpft_pkg::MapShift;
		return s[31:0];
	endfunction

	function automatic map_item_t transform_point(logic signed [15:0] px, logic signed [15:0] py,
			logic signed [15:0] pz, logic last);
		longint    x, y, z, d, h, lo, hi, tx, ty;
		map_item_t r;
		x = px;
		y = py;
		z = pz;
		r = '0;
		r.last = last;
		d = x * x + y * y;
		// planar range window, then the near-behind exclusion zone
		if (d > longint'(cfg_regs[lpft_pkg::REG_MIN_RANGE])
				&& d < longint'(cfg_regs[lpft_pkg::REG_MAX_RANGE])
				&& !(x < 0 && d < longint'(lpft_pkg::BehindLimit))) begin
			h  = row_dot(cfg_regs[lpft_pkg::REG_ROT_ROW_Z], x, y, z);
			lo = row_coef(cfg_regs[lpft_pkg::REG_HEIGHT_MIN], 0)
				* (longint'(1) <<< lpft_pkg::FracBits);
			hi = row_coef(cfg_regs[lpft_pkg::REG_HEIGHT_MAX], 0)
				* (longint'(1) <<< lpft_pkg::FracBits);
			if (h > lo && h < hi) begin
				tx = row_dot(cfg_regs[lpft_pkg::REG_ROT_ROW_X], x, y, z) +
					row_coef(cfg_regs[lpft_pkg::REG_ROT_ROW_X], 3)
					* (longint'(1) <<< lpft_pkg::FracBits);
				ty = row_dot(cfg_regs[lpft_pkg::REG_ROT_ROW_Y], x, y, z) +
					row_coef(cfg_regs[lpft_pkg::REG_ROT_ROW_Y], 3)
					* (longint'(1) <<< lpft_pkg::FracBits);
				r.map_x = scale_to_map(tx);
				r.map_y = scale_to_map(ty);
				r.keep  = 1'b1;
			end
		end
		return r;
	endfunction

	// ---------------------------------------------------------------- result side

	// receiver drops ready at random, about 12 percent of the time, unless quiet
	always @(posedge clk)
		m_axis_tready <= quiet || ($urandom_range(99) >= 12);

	// every accepted result is compared with the oldest prediction
	always @(posedge clk) begin : check_item
		map_item_t want;
		if (arst_n && m_axis_tvalid === 1'b1 && m_axis_tready) begin
			if (pending_maps.size() == 0) begin
				errors++;
				$display("%0t: unexpected item, expected none, got map_x %h map_y %h keep %b last %b",
					$time, m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tuser, m_axis_tlast);
			end else begin
				want = pending_maps.pop_front();
				if (m_axis_tdata[31:0] !== want.map_x) begin
					errors++;
					$display("%0t: map_x expected %h got %h", $time, want.map_x, m_axis_tdata[31:0]);
				end
				if (m_axis_tdata[63:32] !== want.map_y) begin
					errors++;
					$display("%0t: map_y expected %h got %h", $time, want.map_y, m_axis_tdata[63:32]);
				end
				if (m_axis_tuser !== want.keep) begin
					errors++;
					$display("%0t: keep expected %b got %b", $time, want.keep, m_axis_tuser);
				end
				if (m_axis_tlast !== want.last) begin
					errors++;
					$display("%0t: last expected %b got %b", $time, want.last, m_axis_tlast);
				end
			end
		end
	end

	// ---------------------------------------------------------------- point side

	// offer one point, with an occasional random gap before it, and predict its result
	task automatic send_point(logic signed [15:0] x, logic signed [15:0] y,
			logic signed [15:0] z, logic last);
		if (!quiet && $urandom_range(99) < 12) begin
			s_axis_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < 30);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {z, y, x};
		s_axis_tlast  <= last;
		do @(posedge clk); while (!s_axis_tready);
		pending_maps = {pending_maps, transform_point(x, y, z, last)};
	endtask

	// stop offering and let every predicted result come out
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (pending_maps.size() != 0)
			@(posedge clk);
	endtask

	// mostly short vectors so that points land inside the range windows,
	// a quarter full-scale so every bit toggles
	function automatic logic [15:0] rand_coord();
		int k;
		if ($urandom_range(3) == 0)
			return 16'($urandom);
		k = $urandom_range(8, 14);
		return 16'(int'($urandom_range(0, (1 << (k + 1)) - 1)) - (1 << k));
	endfunction

	task automatic send_random_points(int count);
		for (int i = 0; i < count; i++)
			send_point(rand_coord(), rand_coord(), rand_coord(), $urandom_range(15) == 0);
	endtask

	// ---------------------------------------------------------------- register port

	task automatic apb_read(input lpft_pkg::lpft_reg_t r, output logic [63:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= lpft_pkg::CfgAddrW'({r, 3'b000});
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		value = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	function automatic logic [63:0] reg_mask(lpft_pkg::lpft_reg_t r);
		case (r)
			lpft_pkg::REG_MIN_RANGE, lpft_pkg::REG_MAX_RANGE:
				return 64'h0000_0000_7FFF_FFFF;
			lpft_pkg::REG_HEIGHT_MIN, lpft_pkg::REG_HEIGHT_MAX, lpft_pkg::REG_CELLS_PM:
				return 64'h0000_0000_0000_FFFF;
			default: return '1;
		endcase
	endfunction

	// write the raw value, expect it masked to the register width on read back
	task automatic write_reg(lpft_pkg::lpft_reg_t r, logic [63:0] value);
		logic [63:0] got;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= lpft_pkg::CfgAddrW'({r, 3'b000});
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		cfg_regs[r] = value & reg_mask(r);
		apb_read(r, got);
		if (got !== cfg_regs[r]) begin
			errors++;
			$display("%0t: register %s expected %h got %h", $time, r.name(), cfg_regs[r], got);
		end
	endtask

	// rewrite the whole register file; only ever called with the pipeline empty
	task automatic load_setting(logic [63:0] row_x, logic [63:0] row_y, logic [63:0] row_z,
			logic [63:0] min_sq, logic [63:0] max_sq, logic [63:0] h_min, logic [63:0] h_max,
			logic [63:0] cells);
		write_reg(lpft_pkg::REG_ROT_ROW_X, row_x);
		write_reg(lpft_pkg::REG_ROT_ROW_Y, row_y);
		write_reg(lpft_pkg::REG_ROT_ROW_Z, row_z);
		write_reg(lpft_pkg::REG_MIN_RANGE, min_sq);
		write_reg(lpft_pkg::REG_MAX_RANGE, max_sq);
		write_reg(lpft_pkg::REG_HEIGHT_MIN, h_min);
		write_reg(lpft_pkg::REG_HEIGHT_MAX, h_max);
		write_reg(lpft_pkg::REG_CELLS_PM, cells);
	endtask

	// three coefficients within +-1.0 and a random translation, or fully random bits
	function automatic logic [63:0] rand_row(bit wild);
		logic [63:0] row;
		if (wild)
			return {$urandom, $urandom};
		for (int s = 0; s < 3; s++)
			row[16*s +: 16] = 16'(int'($urandom_range(0, 32768)) - 16384);
		row[63:48] = 16'($urandom);
		return row;
	endfunction

	// ---------------------------------------------------------------- tests

	// registers come out of reset with their documented values
	task automatic test_register_reset();
		logic [63:0] got;
		cfg_regs[lpft_pkg::REG_ROT_ROW_X]  = lpft_pkg::RotRowXReset;
		cfg_regs[lpft_pkg::REG_ROT_ROW_Y]  = lpft_pkg::RotRowYReset;
		cfg_regs[lpft_pkg::REG_ROT_ROW_Z]  = lpft_pkg::RotRowZReset;
		cfg_regs[lpft_pkg::REG_MIN_RANGE]  = 64'(lpft_pkg::MinRangeReset);
		cfg_regs[lpft_pkg::REG_MAX_RANGE]  = 64'(lpft_pkg::MaxRangeReset);
		cfg_regs[lpft_pkg::REG_HEIGHT_MIN] = 64'(lpft_pkg::HeightMinReset);
		cfg_regs[lpft_pkg::REG_HEIGHT_MAX] = 64'(lpft_pkg::HeightMaxReset);
		cfg_regs[lpft_pkg::REG_CELLS_PM]   = 64'(lpft_pkg::CellsPmReset);
		for (int i = 0; i < 8; i++) begin
			apb_read(lpft_pkg::lpft_reg_t'(i), got);
			if (got !== cfg_regs[i]) begin
				errors++;
				$display("%0t: reset value of register %0d expected %h got %h",
					$time, i, cfg_regs[i], got);
			end
		end
	endtask

	// edges of each test under the reset setting: 30 m range, 0.4 m inner radius, behind zone
	// of half a square metre in range squared, +-1 m height window, identity rotation
	task automatic test_directed_points();
		send_point(0, 0, 0, 1'b0);                 // origin, below min range
		send_point(204, 0, 0, 1'b0);               // just inside the inner radius
		send_point(205, 0, 0, 1'b0);               // just outside it
		send_point(15359, 0, 0, 1'b0);             // just under max range
		send_point(15360, 0, 0, 1'b1);             // exactly max range, dropped
		send_point(0, -15359, 0, 1'b0);
		send_point(-362, 0, 0, 1'b0);              // behind and inside the zone
		send_point(-363, 0, 0, 1'b0);              // behind, just outside
		send_point(-256, 256, 0, 1'b0);            // behind, exactly on the zone limit
		send_point(-256, 255, 0, 1'b0);            // behind, just inside the zone
		send_point(255, -256, 0, 1'b0);            // in front, same distance, kept
		send_point(1000, 0, 511, 1'b0);            // height just under the top
		send_point(1000, 0, 512, 1'b0);            // height on the top bound
		send_point(1000, 0, -511, 1'b0);
		send_point(1000, 0, -512, 1'b1);           // height on the bottom bound
		send_point(32767, 32767, 32767, 1'b0);     // full-scale corners
		send_point(-32768, -32768, -32768, 1'b1);
		send_point(32767, 0, 0, 1'b0);
		send_point(-7000, -5000, 100, 1'b1);
		send_point(10000, -10000, -300, 1'b0);
		send_point(12345, -3210, 77, 1'b1);
		wait_drained();
	endtask

	// extreme register settings, each with corner and random points
	task automatic test_extreme_settings();
		// widest windows, largest coefficients and scale; high register bits must be ignored
		load_setting(64'h7FFF_8000_8000_8000, 64'h8000_7FFF_7FFF_7FFF, 64'h0,
			64'hFFFF_FFFF_8000_0000, '1, 64'hFFFF_FFFF_FFFF_8000, 64'hFFFF_0000_0000_7FFF,
			64'hFFFF_FFFF_FFFF_FFFF);
		for (int c = 0; c < 8; c++)
			send_point(c[0] ? 16'sh7FFF : 16'sh8000, c[1] ? 16'sh7FFF : 16'sh8000,
				c[2] ? 16'sh7FFF : 16'sh8000, c == 7);
		send_point(16'sh7FFF, 0, 16'sh8000, 1'b0);
		send_point(0, 16'sh8000, 16'sh7FFF, 1'b0);
		send_random_points(25);
		wait_drained();

		// everything zero: no range passes
		load_setting('0, '0, '0, '0, '0, '0, '0, '0);
		send_point(0, 0, 0, 1'b1);
		send_random_points(20);
		wait_drained();

		// min equal to max closes the range window completely
		load_setting(rand_row(1'b0), rand_row(1'b0), '0, 64'h0010_0000, 64'h0010_0000,
			64'hFFFF_FFFF_FFFF_8000, 64'h7FFF, 64'h0100);
		send_point(1024, 0, 0, 1'b0);
		send_random_points(20);
		wait_drained();

		// height window one LSB either side of zero, smallest nonzero scale
		load_setting(64'h0000_8000_8000_8000, 64'hFFFF_8000_8000_8000, 64'h0000_0000_0000_4000,
			'0, 64'h7FFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'h1, 64'h1);
		send_point(0, 5000, 0, 1'b0);
		send_point(-1000, 5000, 0, 1'b1);
		send_random_points(25);
		wait_drained();
	endtask

	// random settings and points, one phase with no idling and one with a mid-run pause
	task automatic test_random_points();
		bit wild;
		for (int p = 0; p < 6; p++) begin
			wild = ($urandom_range(3) == 0);
			load_setting(rand_row(wild), rand_row(wild), rand_row(wild),
				64'($urandom_range(0, 1 << 18)), 64'($urandom_range(1 << 24, 32'h7FFF_FFFF)),
				64'(-int'($urandom_range(0, 32768))), 64'($urandom_range(0, 32767)),
				64'($urandom_range(0, 65535)));
			quiet = (p == 3);
			if (p == 1) begin
				send_random_points(45);
				// sender holds off until the pipeline has emptied
				wait_drained();
				send_random_points(50);
			end else begin
				send_random_points(95);
			end
			wait_drained();
			quiet = 1'b0;
		end
	endtask

	// ---------------------------------------------------------------- sequence

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tlast  = 1'b0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_register_reset();
		test_directed_points();
		test_extreme_settings();
		test_random_points();

		wait_drained();
		// wait for any stray result to come out
		repeat (12) @(posedge clk);
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
